@@ rtl/gdsc_pkg.sv @@
// shared types, constants and calendar tables for the date / serial converter
package gdsc_pkg;

  // reciprocal constants for division by 100 (shift 20) and by 365 (shift 32)
  localparam logic [13:0] K100        = 14'd10486;
  localparam int unsigned K100_SHIFT  = 20;
  localparam logic [23:0] K365        = 24'd11767034;
  localparam int unsigned K365_SHIFT  = 32;
  localparam logic [8:0]  DAYS_IN_YEAR = 9'd365;
  localparam logic [6:0]  YEARS_IN_CENTURY = 7'd100;
  localparam logic [8:0]  DOY_MAX     = 9'd366;

  typedef enum logic [2:0] {
    FUNC_TO_SERIAL_UNUSED = 3'd0
  } unused_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_YMUL,
    OP_YSET,
    OP_DB_MUL,
    OP_DB_LEAP,
    OP_DB_SUM,
    OP_CHECK,
    OP_SERIAL,
    OP_MONTH,
    OP_DAY,
    OP_OUT
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROUTE,
    ST_YMUL,
    ST_YSET,
    ST_DB_MUL,
    ST_DB_LEAP,
    ST_DB_SUM,
    ST_CHECK,
    ST_SERIAL,
    ST_MONTH,
    ST_DAY,
    ST_FIN
  } state_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic func;
    logic sn_ok;
    logic db_ge_sn;
  } status_t;

  // days of a common year before the first of month m (1..12)
  function automatic logic [8:0] month_start_f(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // days in month m (1..12) of a common year, zero for a bad month
  function automatic logic [4:0] month_len_f(input logic [3:0] m);
    logic [4:0] r;
    case (m)
      4'd2:                                r = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:             r = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10,
      4'd12:                               r = 5'd31;
      default:                             r = 5'd0;
    endcase
    return r;
  endfunction

  // remainder mod 7 by folding octal digits (8 == 1 mod 7)
  function automatic logic [2:0] mod7_f(input logic [21:0] v);
    logic [23:0] w;
    logic [5:0]  s1;
    logic [3:0]  s2;
    logic [2:0]  s3;
    w  = {2'b00, v};
    s1 = '0;
    for (int i = 0; i < 8; i++) begin
      s1 = s1 + 6'(w[3*i +: 3]);
    end
    s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
    s3 = s2[2:0] + 3'(s2[3]);
    return (s3 == 3'd7) ? 3'd0 : s3;
  endfunction

endpackage

@@ rtl/gregorian_date_serial_converter_top.sv @@
// Gregorian date to serial day number converter (and back), one request at a time.
// func 0 checks day/month/year and returns the serial number counted from 1 January
// BASE_YEAR (serial 1); func 1 turns a serial number into day/month/year. Every result
// carries serial mod 7 as weekday and a valid flag. A date request makes one pass of the
// shared year day count unit and then forms its serial number. A serial request estimates
// the year as serial/365 and then makes k downward year corrections, where k is at most 6
// with the default years and 8 over the widest year range, each correction being one pass
// of the shared year day count unit; an out-of-range serial number goes straight to the
// result. A new request is taken as soon as the sequencer is idle, even while the previous
// result still waits in the output register.
module gregorian_date_serial_converter_top
  import gdsc_pkg::*;
#(
  parameter int unsigned BASE_YEAR = 1601,
  parameter int unsigned MAX_YEAR  = 9999
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [4:0]  day_i,
  input  logic [3:0]  month_i,
  input  logic [13:0] year_i,
  input  logic [21:0] day_number_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [21:0] serial_out_o,
  output logic [4:0]  day_out_o,
  output logic [3:0]  month_out_o,
  output logic [13:0] year_out_o,
  output logic [2:0]  weekday_o,
  output logic        valid_res_o
);

  cmd_t    cmd;
  status_t status;

  gdsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  gdsc_dp #(
    .BASE_YEAR (BASE_YEAR),
    .MAX_YEAR  (MAX_YEAR)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .func_i       (func_i),
    .day_i        (day_i),
    .month_i      (month_i),
    .year_i       (year_i),
    .day_number_i (day_number_i),
    .serial_out_o (serial_out_o),
    .day_out_o    (day_out_o),
    .month_out_o  (month_out_o),
    .year_out_o   (year_out_o),
    .weekday_o    (weekday_o),
    .valid_res_o  (valid_res_o)
  );

endmodule

@@ rtl/gdsc_ctrl.sv @@
// sequencer for the date / serial converter
module gdsc_ctrl
  import gdsc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output cmd_t    cmd_o,
  input  status_t status_i
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_ROUTE;
        end
      end
      ST_ROUTE: begin
        if (!status_i.func) begin
          state_d = ST_DB_MUL;
        end else if (status_i.sn_ok) begin
          state_d = ST_YMUL;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_YMUL: begin
        cmd_o.op = OP_YMUL;
        state_d  = ST_YSET;
      end
      ST_YSET: begin
        cmd_o.op = OP_YSET;
        state_d  = ST_DB_MUL;
      end
      ST_DB_MUL: begin
        cmd_o.op = OP_DB_MUL;
        state_d  = ST_DB_LEAP;
      end
      ST_DB_LEAP: begin
        cmd_o.op = OP_DB_LEAP;
        state_d  = ST_DB_SUM;
      end
      ST_DB_SUM: begin
        cmd_o.op = OP_DB_SUM;
        state_d  = status_i.func ? ST_CHECK : ST_SERIAL;
      end
      ST_CHECK: begin
        // year estimate is never low, so step it down until it fits
        cmd_o.op = OP_CHECK;
        state_d  = status_i.db_ge_sn ? ST_DB_MUL : ST_MONTH;
      end
      ST_SERIAL: begin
        cmd_o.op = OP_SERIAL;
        state_d  = ST_FIN;
      end
      ST_MONTH: begin
        cmd_o.op = OP_MONTH;
        state_d  = ST_DAY;
      end
      ST_DAY: begin
        cmd_o.op = OP_DAY;
        state_d  = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op = OP_OUT;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.op == OP_OUT) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  a_out_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_OUT) |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a waiting result");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != ST_IDLE))
    else $error("request accepted but sequencer stayed idle");

  a_check_func: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHECK) |-> status_i.func)
    else $error("year search entered on a date request");
`endif

endmodule

@@ rtl/gdsc_dp.sv @@
// datapath: year day count, year search, month split, result register
module gdsc_dp
  import gdsc_pkg::*;
#(
  parameter int unsigned BASE_YEAR = 1601,
  parameter int unsigned MAX_YEAR  = 9999
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output status_t     status_o,
  input  logic        func_i,
  input  logic [4:0]  day_i,
  input  logic [3:0]  month_i,
  input  logic [13:0] year_i,
  input  logic [21:0] day_number_i,
  output logic [21:0] serial_out_o,
  output logic [4:0]  day_out_o,
  output logic [3:0]  month_out_o,
  output logic [13:0] year_out_o,
  output logic [2:0]  weekday_o,
  output logic        valid_res_o
);

  localparam int LeapsBase = (BASE_YEAR - 1) / 4 - (BASE_YEAR - 1) / 100
                           + (BASE_YEAR - 1) / 400;
  localparam int LeapsMax  = MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400;
  localparam int MaxSerial = (MAX_YEAR < BASE_YEAR) ? 0
                           : (MAX_YEAR + 1 - BASE_YEAR) * 365 + LeapsMax - LeapsBase;
  localparam logic [22:0] MaxSerialC = 23'(MaxSerial);
  localparam logic [11:0] LeapsBaseC = 12'(LeapsBase);
  localparam logic [13:0] BaseY      = 14'(BASE_YEAR);
  localparam logic [13:0] MaxY       = 14'(MAX_YEAR);

  logic        func_q, sn_ok_q, ok_q, leap_q;
  logic [4:0]  day_q, dd_q;
  logic [3:0]  month_q, m_q;
  logic [13:0] year_q, y_q;
  logic [21:0] sn_q;
  logic [45:0] p365_q;
  logic [27:0] p100_q;
  logic [22:0] m365_q, db_q, ser_q;
  logic [11:0] leaps_q;
  logic [8:0]  doy_q;

  logic [21:0] serial_out_q;
  logic [4:0]  day_out_q;
  logic [3:0]  month_out_q;
  logic [13:0] year_out_q;
  logic [2:0]  weekday_q;
  logic        valid_res_q;

  logic        sn_ok_c, leap_c, date_ok_c, db_ge_sn_c;
  logic [7:0]  q100_c;
  logic [13:0] r100_c;
  logic [11:0] leaps_c;
  logic [22:0] ser_c;
  logic [4:0]  len_c;
  logic [3:0]  mcnt_c;
  logic [21:0] res_serial_c;

  assign sn_ok_c = (day_number_i != '0) && ({1'b0, day_number_i} <= MaxSerialC);

  // leap test and leap count for y_q from the y/100 quotient
  assign q100_c  = p100_q[K100_SHIFT +: 8];
  assign r100_c  = y_q - 14'(14'(q100_c) * 14'(YEARS_IN_CENTURY));
  assign leap_c  = ((y_q[1:0] == 2'b00) && (r100_c != '0))
                 || ((r100_c == '0) && (q100_c[1:0] == 2'b00));
  assign leaps_c = 12'(y_q >> 2) - 12'(q100_c) + 12'(q100_c >> 2) - 12'(leap_c);

  assign db_ge_sn_c = (db_q >= {1'b0, sn_q});

  assign len_c     = month_len_f(month_q) + 5'(leap_q && (month_q == 4'd2));
  assign date_ok_c = (year_q >= BaseY) && (year_q <= MaxY)
                   && (month_q inside {[4'd1:4'd12]})
                   && (day_q != '0) && (day_q <= len_c);
  assign ser_c     = db_q + 23'(month_start_f(month_q)) + 23'(day_q)
                   + 23'(leap_q && (month_q >= 4'd3));

  // month = 1 + number of later month starts that lie before the day of year
  always_comb begin
    mcnt_c = 4'd1;
    for (int k = 2; k <= 12; k++) begin
      if ((month_start_f(4'(k)) + 9'(leap_q && (k >= 3))) < doy_q) begin
        mcnt_c = mcnt_c + 4'd1;
      end
    end
  end

  assign res_serial_c = func_q ? sn_q : (ok_q ? ser_q[21:0] : '0);

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        func_q  <= func_i;
        day_q   <= day_i;
        month_q <= month_i;
        year_q  <= year_i;
        sn_q    <= day_number_i;
        y_q     <= year_i;
        sn_ok_q <= sn_ok_c;
        ok_q    <= func_i && sn_ok_c;
      end
      OP_YMUL: begin
        p365_q <= 46'(sn_q) * 46'(K365);
      end
      OP_YSET: begin
        y_q <= BaseY + p365_q[K365_SHIFT +: 14];
      end
      OP_DB_MUL: begin
        p100_q <= 28'(y_q) * 28'(K100);
        m365_q <= 23'(y_q - BaseY) * 23'(DAYS_IN_YEAR);
      end
      OP_DB_LEAP: begin
        leap_q  <= leap_c;
        leaps_q <= leaps_c;
      end
      OP_DB_SUM: begin
        db_q <= m365_q + 23'(leaps_q) - 23'(LeapsBaseC);
      end
      OP_CHECK: begin
        if (db_ge_sn_c) begin
          y_q <= y_q - 14'd1;
        end else begin
          doy_q <= 9'(sn_q - db_q[21:0]);
        end
      end
      OP_SERIAL: begin
        ser_q <= ser_c;
        ok_q  <= date_ok_c && !ser_c[22];
      end
      OP_MONTH: begin
        m_q <= mcnt_c;
      end
      OP_DAY: begin
        dd_q <= 5'(doy_q - month_start_f(m_q) - 9'(leap_q && (m_q >= 4'd3)));
      end
      OP_OUT: begin
        serial_out_q <= res_serial_c;
        weekday_q    <= mod7_f(res_serial_c);
        day_out_q    <= func_q ? (ok_q ? dd_q : '0) : day_q;
        month_out_q  <= func_q ? (ok_q ? m_q : '0) : month_q;
        year_out_q   <= func_q ? (ok_q ? y_q : '0) : year_q;
        valid_res_q  <= ok_q;
      end
      default: begin
      end
    endcase
  end

  assign status_o.func     = func_q;
  assign status_o.sn_ok    = sn_ok_q;
  assign status_o.db_ge_sn = db_ge_sn_c;

  assign serial_out_o = serial_out_q;
  assign day_out_o    = day_out_q;
  assign month_out_o  = month_out_q;
  assign year_out_o   = year_out_q;
  assign weekday_o    = weekday_q;
  assign valid_res_o  = valid_res_q;

`ifndef ASSERT_OFF
  a_doy_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_MONTH) |-> ((doy_q != '0) && (doy_q <= DOY_MAX)))
    else $error("day of year out of range after year search");

  a_valid_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_OUT && ok_q) |=> (serial_out_o != '0))
    else $error("valid result with zero serial number");
`endif

endmodule
